/* hdl/hpvc_pkg.sv */
// ----------------------------------------------------------------------------
// hpvc_pkg: shared types and constants for the heading PID velocity command
// Field widths, register indexes, controller codes and the speed ramp table.
// ----------------------------------------------------------------------------
package hpvc_pkg;

  // Field widths.
  localparam int ANGLE_W    = 15;
  localparam int POS_W      = 24;
  localparam int SPEED_W    = 15;
  localparam int ANG_W      = 24;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Internal datapath widths.
  localparam int ERR_W  = 16;
  localparam int DIFF_W = 17;
  localparam int DPOS_W = 25;
  localparam int ED_W   = 26;
  localparam int EI_W   = 32;
  localparam int MA_W   = 25;
  localparam int MB_W   = 32;
  localparam int PROD_W = 57;
  localparam int D2_W   = 49;
  localparam int ACC_W  = 49;
  localparam int P_W    = 56;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SHAPE = 3'd7;

  // Register reset values.
  localparam logic [COEF_W-1:0] GAIN_P_RST      = 16'd256;
  localparam logic [COEF_W-1:0] GAIN_I_RST      = 16'd0;
  localparam logic [COEF_W-1:0] GAIN_D_RST      = 16'd0;
  localparam logic [COEF_W-1:0] TICK_PERIOD_RST = 16'd6554;
  localparam logic [COEF_W-1:0] TICK_RATE_RST   = 16'd2560;
  localparam logic [COEF_W-1:0] SPEED_SHAPE_RST = 16'd256;

  // Angle constants in Q3.12.
  localparam logic signed [ERR_W-1:0] PI_Q12     = 16'sd12868;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 16'sd25736;

  // Output limits.
  localparam logic [SPEED_W-1:0]      SPEED_TOP = 15'd17039;
  localparam logic signed [ANG_W-1:0] ANG_MAX   = 24'sh7FFFFF;
  localparam logic signed [ANG_W-1:0] ANG_MIN   = 24'sh800000;

  // Speed ramp table; the depth must be a power of two.
  localparam int  RAMP_DEPTH     = 256;
  localparam int  RAMP_IDX_W     = $clog2(RAMP_DEPTH);
  localparam int  RAMP_SEL_MSB   = 35;
  localparam longint SPEED_SCALE = 64'sd279172874;
  localparam longint ONE_Q30     = longint'(1) <<< 30;

  // Decay factor exp(-16/depth) in Q0.30 from a Taylor series through the 20th term.
  // Each term h^n/n! is formed from the one before it.
  localparam longint RAMP_H   = (longint'(16) <<< 30) / RAMP_DEPTH;
  localparam longint RAMP_T1  = (ONE_Q30 * RAMP_H) / (longint'(1) <<< 30);
  localparam longint RAMP_T2  = (RAMP_T1 * RAMP_H) / (longint'(2) <<< 30);
  localparam longint RAMP_T3  = (RAMP_T2 * RAMP_H) / (longint'(3) <<< 30);
  localparam longint RAMP_T4  = (RAMP_T3 * RAMP_H) / (longint'(4) <<< 30);
  localparam longint RAMP_T5  = (RAMP_T4 * RAMP_H) / (longint'(5) <<< 30);
  localparam longint RAMP_T6  = (RAMP_T5 * RAMP_H) / (longint'(6) <<< 30);
  localparam longint RAMP_T7  = (RAMP_T6 * RAMP_H) / (longint'(7) <<< 30);
  localparam longint RAMP_T8  = (RAMP_T7 * RAMP_H) / (longint'(8) <<< 30);
  localparam longint RAMP_T9  = (RAMP_T8 * RAMP_H) / (longint'(9) <<< 30);
  localparam longint RAMP_T10 = (RAMP_T9 * RAMP_H) / (longint'(10) <<< 30);
  localparam longint RAMP_T11 = (RAMP_T10 * RAMP_H) / (longint'(11) <<< 30);
  localparam longint RAMP_T12 = (RAMP_T11 * RAMP_H) / (longint'(12) <<< 30);
  localparam longint RAMP_T13 = (RAMP_T12 * RAMP_H) / (longint'(13) <<< 30);
  localparam longint RAMP_T14 = (RAMP_T13 * RAMP_H) / (longint'(14) <<< 30);
  localparam longint RAMP_T15 = (RAMP_T14 * RAMP_H) / (longint'(15) <<< 30);
  localparam longint RAMP_T16 = (RAMP_T15 * RAMP_H) / (longint'(16) <<< 30);
  localparam longint RAMP_T17 = (RAMP_T16 * RAMP_H) / (longint'(17) <<< 30);
  localparam longint RAMP_T18 = (RAMP_T17 * RAMP_H) / (longint'(18) <<< 30);
  localparam longint RAMP_T19 = (RAMP_T18 * RAMP_H) / (longint'(19) <<< 30);
  localparam longint RAMP_T20 = (RAMP_T19 * RAMP_H) / (longint'(20) <<< 30);
  localparam longint RAMP_Q   = ONE_Q30
                              - RAMP_T1 + RAMP_T2 - RAMP_T3 + RAMP_T4
                              - RAMP_T5 + RAMP_T6 - RAMP_T7 + RAMP_T8
                              - RAMP_T9 + RAMP_T10 - RAMP_T11 + RAMP_T12
                              - RAMP_T13 + RAMP_T14 - RAMP_T15 + RAMP_T16
                              - RAMP_T17 + RAMP_T18 - RAMP_T19 + RAMP_T20;

  typedef logic [RAMP_DEPTH-1:0][SPEED_W-1:0] ramp_tbl_t;

  // Entry i is 0.26*(1 - exp(-16*i/depth)) in Q0.16, with the decay factor
  // applied repeatedly in Q0.30.
  function automatic ramp_tbl_t build_ramp();
    longint    e;
    longint    s;
    ramp_tbl_t tbl;
    e = ONE_Q30;
    for (int i = 0; i < RAMP_DEPTH; i++) begin
      if (i > 0) begin
        e = (e * RAMP_Q + (longint'(1) <<< 29)) >>> 30;
      end
      s = (SPEED_SCALE * (ONE_Q30 - e) + (longint'(1) <<< 43)) >>> 44;
      tbl[i] = s[SPEED_W-1:0];
    end
    return tbl;
  endfunction

  localparam ramp_tbl_t RAMP_TABLE = build_ramp();

  // Configuration register set.
  typedef struct packed {
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic [COEF_W-1:0]       gain_p;
    logic [COEF_W-1:0]       gain_i;
    logic [COEF_W-1:0]       gain_d;
    logic [COEF_W-1:0]       tick_period;
    logic [COEF_W-1:0]       tick_rate;
    logic [COEF_W-1:0]       speed_shape;
  } cfg_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
    ST_M8, ST_M9, ST_FIN, ST_OUT
  } state_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [3:0] {
    MS_TP_E, MS_RATE_DIFF, MS_DX_DX, MS_DY_DY, MS_GP_E, MS_GD_ED,
    MS_GI_EI, MS_SH_LO, MS_SH_HI
  } mul_sel_t;

  // What the datapath does with the registered product.
  typedef enum logic [3:0] {
    AC_NONE, AC_EI, AC_ED, AC_D2_SET, AC_D2_ADD, AC_ACC_SET, AC_ACC_ADD,
    AC_P_SET, AC_P_ADD
  } acc_op_t;

  typedef struct packed {
    logic     capture;
    logic     calc_err;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/hpvc_in_if.sv */
// ----------------------------------------------------------------------------
// hpvc_in_if: request channel into the heading controller
// Valid/ready handshake carrying one control tick of measurements.
// ----------------------------------------------------------------------------
interface hpvc_in_if;
  import hpvc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] target_heading;
  logic signed [ANGLE_W-1:0] robot_yaw;
  logic signed [POS_W-1:0]   robot_x;
  logic signed [POS_W-1:0]   robot_y;

  modport source (
    output valid, target_heading, robot_yaw, robot_x, robot_y,
    input  ready
  );

  modport sink (
    input  valid, target_heading, robot_yaw, robot_x, robot_y,
    output ready
  );
endinterface

/* hdl/hpvc_out_if.sv */
// ----------------------------------------------------------------------------
// hpvc_out_if: result channel out of the heading controller
// Valid/ready handshake carrying the speed commands of one control tick.
// ----------------------------------------------------------------------------
interface hpvc_out_if;
  import hpvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SPEED_W-1:0]      linear_speed;
  logic signed [ANG_W-1:0] angular_speed;
  logic                    turn_saturated;

  modport source (
    output valid, linear_speed, angular_speed, turn_saturated,
    input  ready
  );

  modport sink (
    input  valid, linear_speed, angular_speed, turn_saturated,
    output ready
  );
endinterface

/* hdl/hpvc_cfg.sv */
// ----------------------------------------------------------------------------
// hpvc_cfg: configuration register file
// Holds goal position, PID gains, tick timing and the speed ramp coefficient.
// ----------------------------------------------------------------------------
module hpvc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hpvc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hpvc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hpvc_pkg::cfg_t                   cfg
);
  import hpvc_pkg::*;

  cfg_t cfg_r;

  // Register writes; every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x      <= '0;
      cfg_r.goal_y      <= '0;
      cfg_r.gain_p      <= GAIN_P_RST;
      cfg_r.gain_i      <= GAIN_I_RST;
      cfg_r.gain_d      <= GAIN_D_RST;
      cfg_r.tick_period <= TICK_PERIOD_RST;
      cfg_r.tick_rate   <= TICK_RATE_RST;
      cfg_r.speed_shape <= SPEED_SHAPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GOAL_X:      cfg_r.goal_x      <= cfg_wdata;
        CFG_GOAL_Y:      cfg_r.goal_y      <= cfg_wdata;
        CFG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata[COEF_W-1:0];
        CFG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata[COEF_W-1:0];
        CFG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata[COEF_W-1:0];
        CFG_TICK_PERIOD: cfg_r.tick_period <= cfg_wdata[COEF_W-1:0];
        CFG_TICK_RATE:   cfg_r.tick_rate   <= cfg_wdata[COEF_W-1:0];
        CFG_SPEED_SHAPE: cfg_r.speed_shape <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/hpvc_ctrl.sv */
// ----------------------------------------------------------------------------
// hpvc_ctrl: sequencer for the heading controller
// Steps the datapath through error wrap, nine shared multiplies, a final add and output.
// ----------------------------------------------------------------------------
module hpvc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hpvc_pkg::dp_stat_t  stat,
  output hpvc_pkg::dp_cmd_t   cmd
);
  import hpvc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_M6;
      ST_M6:   state_nxt = ST_M7;
      ST_M7:   state_nxt = ST_M8;
      ST_M8:   state_nxt = ST_M9;
      ST_M9:   state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (stat.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs. Each multiply step issues one product, and each step after the first
  // consumes the product issued in the step before.
  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.calc_err = 1'b0;
    cmd.mul_sel  = MS_TP_E;
    cmd.acc_op   = AC_NONE;
    cmd.commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_ERR: cmd.calc_err = 1'b1;
      ST_M1:  cmd.mul_sel  = MS_TP_E;
      ST_M2: begin
        cmd.mul_sel = MS_RATE_DIFF;
        cmd.acc_op  = AC_EI;
      end
      ST_M3: begin
        cmd.mul_sel = MS_DX_DX;
        cmd.acc_op  = AC_ED;
      end
      ST_M4: begin
        cmd.mul_sel = MS_DY_DY;
        cmd.acc_op  = AC_D2_SET;
      end
      ST_M5: begin
        cmd.mul_sel = MS_GP_E;
        cmd.acc_op  = AC_D2_ADD;
      end
      ST_M6: begin
        cmd.mul_sel = MS_GD_ED;
        cmd.acc_op  = AC_ACC_SET;
      end
      ST_M7: begin
        cmd.mul_sel = MS_GI_EI;
        cmd.acc_op  = AC_ACC_ADD;
      end
      ST_M8: begin
        cmd.mul_sel = MS_SH_LO;
        cmd.acc_op  = AC_ACC_ADD;
      end
      ST_M9: begin
        cmd.mul_sel = MS_SH_HI;
        cmd.acc_op  = AC_P_SET;
      end
      ST_FIN: cmd.acc_op = AC_P_ADD;
      ST_OUT: cmd.commit = stat.out_free;
      default: begin
      end
    endcase
  end

endmodule

/* hdl/hpvc_dp.sv */
// ----------------------------------------------------------------------------
// hpvc_dp: datapath of the heading controller
// Error wrap, one shared registered multiplier with accumulators, PID state,
// speed ramp lookup and the output register.
// ----------------------------------------------------------------------------
module hpvc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hpvc_pkg::cfg_t                        cfg,
  input  hpvc_pkg::dp_cmd_t                     cmd,
  output hpvc_pkg::dp_stat_t                    stat,
  input  logic signed [hpvc_pkg::ANGLE_W-1:0]   in_heading,
  input  logic signed [hpvc_pkg::ANGLE_W-1:0]   in_yaw,
  input  logic signed [hpvc_pkg::POS_W-1:0]     in_x,
  input  logic signed [hpvc_pkg::POS_W-1:0]     in_y,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [hpvc_pkg::SPEED_W-1:0]          out_linear,
  output logic signed [hpvc_pkg::ANG_W-1:0]     out_angular,
  output logic                                  out_sat
);
  import hpvc_pkg::*;

  // Captured request.
  logic signed [ANGLE_W-1:0] head_r;
  logic signed [ANGLE_W-1:0] yaw_r;
  logic signed [POS_W-1:0]   x_r;
  logic signed [POS_W-1:0]   y_r;

  // Working registers.
  logic signed [ERR_W-1:0]  e_r;
  logic signed [DPOS_W-1:0] dx_r;
  logic signed [DPOS_W-1:0] dy_r;
  logic signed [EI_W-1:0]   ei_r;
  logic signed [ED_W-1:0]   ed_r;
  logic [D2_W-1:0]          d2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [P_W-1:0]           p_r;
  logic signed [PROD_W-1:0] prod_r;

  // Controller state carried between ticks.
  logic signed [EI_W-1:0]  integ_r;
  logic signed [ERR_W-1:0] last_e_r;

  // Output register.
  logic                    out_valid_r;
  logic [SPEED_W-1:0]      linear_r;
  logic signed [ANG_W-1:0] angular_r;
  logic                    sat_r;

  logic signed [ERR_W-1:0]  e_raw;
  logic signed [ERR_W-1:0]  e_wrap;
  logic signed [DIFF_W-1:0] e_diff;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_sh16;
  logic signed [PROD_W-1:0] prod_sh8;
  logic signed [EI_W:0]     ei_sum;
  logic signed [EI_W-1:0]   ei_sat;
  logic signed [ACC_W-1:0]  w_full;
  logic signed [ANG_W-1:0]  w_sat;
  logic                     w_clip;
  logic                     far;
  logic [RAMP_IDX_W-1:0]    ramp_idx;
  logic [SPEED_W-1:0]       speed;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_r <= in_heading;
      yaw_r  <= in_yaw;
      x_r    <= in_x;
      y_r    <= in_y;
    end
  end

  // Heading error, wrapped into [-pi, pi) with one correction.
  always_comb begin
    e_raw = {head_r[ANGLE_W-1], head_r} - {yaw_r[ANGLE_W-1], yaw_r};
    if (e_raw >= PI_Q12) begin
      e_wrap = e_raw - TWO_PI_Q12;
    end else if (e_raw < -PI_Q12) begin
      e_wrap = e_raw + TWO_PI_Q12;
    end else begin
      e_wrap = e_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      e_r  <= e_wrap;
      dx_r <= {cfg.goal_x[POS_W-1], cfg.goal_x} - {x_r[POS_W-1], x_r};
      dy_r <= {cfg.goal_y[POS_W-1], cfg.goal_y} - {y_r[POS_W-1], y_r};
    end
  end

  assign e_diff = {e_r[ERR_W-1], e_r} - {last_e_r[ERR_W-1], last_e_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_TP_E: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.tick_period};
        mul_b = {{(MB_W-ERR_W){e_r[ERR_W-1]}}, e_r};
      end
      MS_RATE_DIFF: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.tick_rate};
        mul_b = {{(MB_W-DIFF_W){e_diff[DIFF_W-1]}}, e_diff};
      end
      MS_DX_DX: begin
        mul_a = dx_r;
        mul_b = {{(MB_W-DPOS_W){dx_r[DPOS_W-1]}}, dx_r};
      end
      MS_DY_DY: begin
        mul_a = dy_r;
        mul_b = {{(MB_W-DPOS_W){dy_r[DPOS_W-1]}}, dy_r};
      end
      MS_GP_E: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.gain_p};
        mul_b = {{(MB_W-ERR_W){e_r[ERR_W-1]}}, e_r};
      end
      MS_GD_ED: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.gain_d};
        mul_b = {{(MB_W-ED_W){ed_r[ED_W-1]}}, ed_r};
      end
      MS_GI_EI: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.gain_i};
        mul_b = ei_r;
      end
      MS_SH_LO: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.speed_shape};
        mul_b = {8'b0, d2_r[23:0]};
      end
      MS_SH_HI: begin
        mul_a = {{(MA_W-COEF_W){1'b0}}, cfg.speed_shape};
        mul_b = {16'b0, d2_r[39:24]};
      end
      default: begin
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Integral update, saturated to the 32-bit signed range.
  assign prod_sh16 = prod_r >>> 16;
  assign prod_sh8  = prod_r >>> 8;
  assign ei_sum    = {integ_r[EI_W-1], integ_r} + prod_sh16[EI_W:0];

  always_comb begin
    if (ei_sum[EI_W] != ei_sum[EI_W-1]) begin
      ei_sat = ei_sum[EI_W] ? {1'b1, {(EI_W-1){1'b0}}} : {1'b0, {(EI_W-1){1'b1}}};
    end else begin
      ei_sat = ei_sum[EI_W-1:0];
    end
  end

  // Consume the registered product.
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      AC_EI:      ei_r  <= ei_sat;
      AC_ED:      ed_r  <= prod_sh8[ED_W-1:0];
      AC_D2_SET:  d2_r  <= prod_r[D2_W-1:0];
      AC_D2_ADD:  d2_r  <= d2_r + prod_r[D2_W-1:0];
      AC_ACC_SET: acc_r <= prod_r[ACC_W-1:0];
      AC_ACC_ADD: acc_r <= acc_r + prod_r[ACC_W-1:0];
      AC_P_SET:   p_r   <= prod_r[P_W-1:0];
      AC_P_ADD:   p_r   <= p_r + {prod_r[31:0], 24'b0};
      default: begin
      end
    endcase
  end

  // Angular speed: scale to Q8.16 and clip.
  assign w_full = acc_r >>> 4;

  always_comb begin
    w_clip = (w_full[ACC_W-1:ANG_W-1] != {(ACC_W-ANG_W+1){1'b0}})
          && (w_full[ACC_W-1:ANG_W-1] != {(ACC_W-ANG_W+1){1'b1}});
    if (w_clip) begin
      w_sat = w_full[ACC_W-1] ? ANG_MIN : ANG_MAX;
    end else begin
      w_sat = w_full[ANG_W-1:0];
    end
  end

  // Linear speed from the ramp table, clamped far from the goal and zero when the shape coefficient is zero.
  assign far      = (d2_r[D2_W-1:40] != '0) || (p_r[P_W-1:36] != '0);
  assign ramp_idx = p_r[RAMP_SEL_MSB -: RAMP_IDX_W];

  always_comb begin
    if (cfg.speed_shape == '0) begin
      speed = '0;
    end else if (far) begin
      speed = SPEED_TOP;
    end else begin
      speed = RAMP_TABLE[ramp_idx];
    end
  end

  // Tick state, updated once per finished request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r  <= '0;
      last_e_r <= '0;
    end else if (cmd.commit) begin
      integ_r  <= ei_r;
      last_e_r <= e_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      linear_r  <= speed;
      angular_r <= w_sat;
      sat_r     <= w_clip;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_linear    = linear_r;
  assign out_angular   = angular_r;
  assign out_sat       = sat_r;

endmodule

/* hdl/heading_pid_velocity_command.sv */
// ----------------------------------------------------------------------------
// heading_pid_velocity_command: heading PID and distance-shaped speed command
// A result reaches the output register after error wrap, nine multiply steps
// and a final add. A new request is taken once that result is committed; the
// nine products share one 25x32 multiplier, one per cycle. Held output stalls.
// Reset (synchronous, rst_n low): registers to defaults, integral and last
// error to zero, output empty.
// ----------------------------------------------------------------------------
module heading_pid_velocity_command (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hpvc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hpvc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  hpvc_in_if.sink                          in_ch,
  hpvc_out_if.source                       out_ch
);
  import hpvc_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers.
  hpvc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer.
  hpvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  hpvc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .in_heading  (in_ch.target_heading),
    .in_yaw      (in_ch.robot_yaw),
    .in_x        (in_ch.robot_x),
    .in_y        (in_ch.robot_y),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_linear  (out_ch.linear_speed),
    .out_angular (out_ch.angular_speed),
    .out_sat     (out_ch.turn_saturated)
  );

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in work");

  // A result follows its request, no sooner than the sequencer allows.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> ##[13:$] out_ch.valid)
    else $error("result missing after request");

  // A clipped turn rate sits at one of the limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.turn_saturated) |->
      (out_ch.angular_speed == ANG_MAX || out_ch.angular_speed == ANG_MIN))
    else $error("saturation flag without a limit value");

  // Linear speed never exceeds the ramp top.
  a_speed_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.linear_speed <= SPEED_TOP))
    else $error("linear speed above ramp top");

endmodule
